/* hdl/stt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table package
// Shared types, operation codes and controller commands for the timer table.
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam int KIND_BITS = 2;
	localparam int HANDLER_BITS = 4;
	localparam int ID_BITS = 32;
	localparam int TIME_W = 48;
	localparam int STATUS_BITS = 2;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_ADD    = 2'd0,
		KIND_STOP   = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_TICK   = 2'd3
	} kind_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK      = 2'd0,
		ST_REFUSED = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef struct packed {
		logic [KIND_BITS-1:0]    kind;
		logic [HANDLER_BITS-1:0] handler;
		logic [ID_BITS-1:0]      interval;
		logic                    fire_once;
		logic [ID_BITS-1:0]      stop_id;
		logic [TIME_W-1:0]       now;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_BITS-1:0]  status;
		logic [ID_BITS-1:0]      new_timer_id;
		logic                    fired;
		logic [ID_BITS-1:0]      fired_timer_id;
		logic [HANDLER_BITS-1:0] fired_handler;
		logic                    deadline_valid;
		logic [TIME_W-1:0]       next_deadline;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY,
		S_MIN,
		S_DONE
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load;      // capture the input transaction, clear scan state
		logic scan;      // examine one slot for the operation
		logic apply;     // commit the operation result
		logic min_scan;  // examine one slot for earliest deadline
		logic publish;   // load the output register
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic last_slot;
	} sts_t;

endpackage

/* hdl/software_timer_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer table
// One-shot and periodic timers with per-handler ownership and next-deadline
// reporting; one result transaction for every input transaction.
// ----------------------------------------------------------------------------
//  Channel | Signals                     | Direction
//  in      | in_valid, in_stall, in_item | command transaction into the block
//  out     | out_valid, out_stall, out_item | result transaction out
//
// Each transaction runs in steps: one slot-serial pass finds the free slot,
// the matching id or the oldest expired timer, or clears the timers of the
// handler being removed; a commit step applies it, and a second slot-serial
// pass finds the earliest deadline. Reset clears all slot valid bits and
// removed handlers at once. A stalled result holds in the output register;
// the next transaction is taken while it waits and runs up to the handoff step.
module software_timer_table_top #(
	parameter int TIMER_SLOTS = 16,
	parameter int HANDLER_SLOTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  stt_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output stt_pkg::out_item_t out_item
);
	import stt_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic out_busy;

	// The output register may be reloaded once its transaction is taken.
	assign out_busy = out_valid && out_stall;

	stt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_busy (out_busy),
		.sts      (sts),
		.cmd      (cmd)
	);

	stt_datapath #(
		.TIMER_SLOTS   (TIMER_SLOTS),
		.HANDLER_SLOTS (HANDLER_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

	// At most one command is issued in any cycle.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command");

	// A published result is presented in the next cycle.
	a_publish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> out_valid)
		else $error("publish without result");

	// Publishing never overwrites a stalled result.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> !(out_valid && out_stall))
		else $error("result overwritten");

	// An accepted transaction is never followed by another acceptance at once.
	a_accept_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("back to back accept");

endmodule

/* hdl/stt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table controller
// Sequences the operation scan, commit, minimum scan and result handoff.
// ----------------------------------------------------------------------------
module stt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          out_busy,
	input  stt_pkg::sts_t sts,
	output stt_pkg::cmd_t cmd
);
	import stt_pkg::*;

	state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_next = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.last_slot) begin
					state_next = S_APPLY;
				end
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_next = S_MIN;
			end
			S_MIN: begin
				cmd.min_scan = 1'b1;
				if (sts.last_slot) begin
					state_next = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_busy) begin
					cmd.publish = 1'b1;
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

endmodule

/* hdl/stt_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table datapath
// Slot registers, the per-slot scan unit and the result register.
// ----------------------------------------------------------------------------
module stt_datapath #(
	parameter int TIMER_SLOTS = 16,
	parameter int HANDLER_SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  stt_pkg::in_item_t   in_item,
	input  stt_pkg::cmd_t       cmd,
	output stt_pkg::sts_t       sts,
	input  logic                out_stall,
	output logic                out_valid,
	output stt_pkg::out_item_t  out_item
);
	import stt_pkg::*;

	localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int HW = (HANDLER_SLOTS > 1) ? $clog2(HANDLER_SLOTS) : 1;
	localparam logic [TIME_W-1:0] TMAX = {TIME_W{1'b1}};

	logic [TIMER_SLOTS-1:0]   valid_q;
	logic [HANDLER_BITS-1:0]  owner_q [TIMER_SLOTS];
	logic [ID_BITS-1:0]       id_q [TIMER_SLOTS];
	logic [TIME_W-1:0]        dl_q [TIMER_SLOTS];
	logic [ID_BITS-1:0]       period_q [TIMER_SLOTS];
	logic [HANDLER_SLOTS-1:0] removed_q;
	logic [ID_BITS-1:0]       last_id_q;

	in_item_t                 req_q;
	logic [SW-1:0]            idx_q;
	logic                     hit_q;
	logic [SW-1:0]            pick_q;
	logic [ID_BITS-1:0]       pick_id_q;
	logic                     ev_q;
	logic [TIME_W-1:0]        ed_q;
	logic [STATUS_BITS-1:0]   status_q;
	logic [ID_BITS-1:0]       new_id_q;
	logic                     fired_q;
	logic [ID_BITS-1:0]       fid_q;
	logic [HANDLER_BITS-1:0]  fh_q;

	logic [TIME_W-1:0]        now_t;
	logic                     h_ok;
	logic                     cur_v;
	logic                     cand;
	logic [ID_BITS-1:0]       id_inc;
	logic [TIME_W-1:0]        add_dl;
	logic [TIME_W-1:0]        per_dl;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [ID_BITS-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + (TIME_W+1)'(b);
		sat_add = s[TIME_W] ? TMAX : s[TIME_W-1:0];
	endfunction

	assign now_t = req_q.now;
	assign h_ok = (32'(req_q.handler) < 32'(HANDLER_SLOTS))
		&& !removed_q[HW'(req_q.handler)];
	assign cur_v = valid_q[idx_q];
	assign id_inc = (last_id_q + ID_BITS'(1) == '0) ? ID_BITS'(1) : last_id_q + ID_BITS'(1);
	assign add_dl = sat_add(now_t, req_q.interval);
	assign per_dl = sat_add(now_t, period_q[pick_q]);
	assign sts.last_slot = (32'(idx_q) == 32'(TIMER_SLOTS - 1));

	always_comb begin
		cand = 1'b0;
		case (req_q.kind)
			KIND_ADD:  cand = !cur_v && !hit_q;
			KIND_STOP: cand = cur_v && (req_q.stop_id != '0)
				&& (id_q[idx_q] == req_q.stop_id) && !hit_q;
			KIND_TICK: cand = cur_v && (dl_q[idx_q] <= now_t)
				&& (!hit_q || id_q[idx_q] < pick_id_q);
			default:   cand = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			removed_q <= '0;
			last_id_q <= '0;
			idx_q     <= '0;
			hit_q     <= 1'b0;
			ev_q      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end
			if (cmd.scan) begin
				if (cand) begin
					hit_q <= 1'b1;
				end
				if (req_q.kind == KIND_REMOVE && h_ok && cur_v
						&& owner_q[idx_q] == req_q.handler) begin
					valid_q[idx_q] <= 1'b0;
				end
				idx_q <= sts.last_slot ? '0 : idx_q + SW'(1);
			end
			if (cmd.apply) begin
				ev_q <= 1'b0;
				case (req_q.kind)
					KIND_ADD: begin
						if (h_ok && hit_q) begin
							last_id_q <= id_inc;
							valid_q[pick_q] <= 1'b1;
						end
					end
					KIND_STOP: begin
						if (hit_q) begin
							valid_q[pick_q] <= 1'b0;
						end
					end
					KIND_REMOVE: begin
						if (32'(req_q.handler) < 32'(HANDLER_SLOTS)) begin
							removed_q[HW'(req_q.handler)] <= 1'b1;
						end
					end
					default: begin
						if (hit_q && period_q[pick_q] == '0) begin
							valid_q[pick_q] <= 1'b0;
						end
					end
				endcase
			end
			if (cmd.min_scan) begin
				if (cur_v && (!ev_q || dl_q[idx_q] < ed_q)) begin
					ev_q <= 1'b1;
				end
				idx_q <= sts.last_slot ? '0 : idx_q + SW'(1);
			end
			if (cmd.publish) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_item;
		end
		if (cmd.scan && cand) begin
			pick_q    <= idx_q;
			pick_id_q <= id_q[idx_q];
		end
		if (cmd.apply) begin
			status_q <= ST_OK;
			new_id_q <= '0;
			fired_q  <= 1'b0;
			fid_q    <= '0;
			fh_q     <= '0;
			ed_q     <= '0;
			case (req_q.kind)
				KIND_ADD: begin
					if (!h_ok) begin
						status_q <= ST_REFUSED;
					end else if (!hit_q) begin
						status_q <= ST_FULL;
					end else begin
						new_id_q         <= id_inc;
						owner_q[pick_q]  <= req_q.handler;
						id_q[pick_q]     <= id_inc;
						dl_q[pick_q]     <= add_dl;
						period_q[pick_q] <= req_q.fire_once ? '0 : req_q.interval;
					end
				end
				KIND_TICK: begin
					if (hit_q) begin
						fired_q <= 1'b1;
						fid_q   <= id_q[pick_q];
						fh_q    <= owner_q[pick_q];
						if (period_q[pick_q] != '0) begin
							dl_q[pick_q] <= per_dl;
						end
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.min_scan && cur_v && (!ev_q || dl_q[idx_q] < ed_q)) begin
			ed_q <= dl_q[idx_q];
		end
		if (cmd.publish) begin
			out_item.status         <= status_q;
			out_item.new_timer_id   <= new_id_q;
			out_item.fired          <= fired_q;
			out_item.fired_timer_id <= fid_q;
			out_item.fired_handler  <= fh_q;
			out_item.deadline_valid <= ev_q;
			out_item.next_deadline  <= ed_q;
		end
	end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table testbench
// Drives add, stop, remove and tick transactions into the timer table through
// a bursty sender and a stalling receiver. A behavioral timer table in the
// bench predicts every result, and the monitor compares each field in order.
// ----------------------------------------------------------------------------
module testbench;
	import stt_pkg::*;

	localparam int SLOTS = 16;
	localparam int OWNERS = 16;
	localparam logic [TIME_W-1:0] TIME_TOP = {TIME_W{1'b1}};
	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;

	always #2 clk = ~clk;

	software_timer_table_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	// Shadow copy of the timer table, updated as each command is accepted.
	logic                    tbl_used[SLOTS];
	logic [HANDLER_BITS-1:0] tbl_owner[SLOTS];
	logic [ID_BITS-1:0]      tbl_id[SLOTS];
	logic [TIME_W-1:0]       tbl_due[SLOTS];
	logic [ID_BITS-1:0]      tbl_period[SLOTS];
	logic                    owner_gone[OWNERS];
	logic [ID_BITS-1:0]      id_counter;

	in_item_t  pending_cmds[$];
	out_item_t expected_results[$];
	logic      hold_until_drained[$];
	int        failures = 0;
	logic      stim_done = 1'b0;

	function automatic logic [TIME_W-1:0] due_sum(logic [TIME_W-1:0] a,
			logic [ID_BITS-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + (TIME_W+1)'(b);
		return s[TIME_W] ? TIME_TOP : s[TIME_W-1:0];
	endfunction

	function automatic out_item_t timer_table_apply(in_item_t c);
		out_item_t r;
		int pick;
		logic [ID_BITS-1:0] nid;
		r = '0;
		pick = -1;
		case (kind_t'(c.kind))
			KIND_ADD: begin
				if (owner_gone[c.handler]) begin
					r.status = ST_REFUSED;
				end else begin
					for (int i = 0; i < SLOTS; i++)
						if (!tbl_used[i] && pick < 0) pick = i;
					if (pick < 0) begin
						r.status = ST_FULL;
					end else begin
						nid = id_counter + 1;
						if (nid == 0) nid = 1;
						id_counter = nid;
						tbl_used[pick] = 1'b1;
						tbl_owner[pick] = c.handler;
						tbl_id[pick] = nid;
						tbl_due[pick] = due_sum(c.now, c.interval);
						tbl_period[pick] = c.fire_once ? '0 : c.interval;
						r.new_timer_id = nid;
					end
				end
			end
			KIND_STOP: begin
				if (c.stop_id != 0)
					for (int i = 0; i < SLOTS; i++)
						if (pick < 0 && tbl_used[i] && tbl_id[i] == c.stop_id) begin
							tbl_used[i] = 1'b0;
							pick = i;
						end
			end
			KIND_REMOVE: begin
				owner_gone[c.handler] = 1'b1;
				for (int i = 0; i < SLOTS; i++)
					if (tbl_used[i] && tbl_owner[i] == c.handler) tbl_used[i] = 1'b0;
			end
			default: begin
				for (int i = 0; i < SLOTS; i++)
					if (tbl_used[i] && tbl_due[i] <= c.now &&
							(pick < 0 || tbl_id[i] < tbl_id[pick])) pick = i;
				if (pick >= 0) begin
					r.fired = 1'b1;
					r.fired_timer_id = tbl_id[pick];
					r.fired_handler = tbl_owner[pick];
					if (tbl_period[pick] != 0)
						tbl_due[pick] = due_sum(c.now, tbl_period[pick]);
					else
						tbl_used[pick] = 1'b0;
				end
			end
		endcase
		for (int i = 0; i < SLOTS; i++)
			if (tbl_used[i] && (!r.deadline_valid || tbl_due[i] < r.next_deadline)) begin
				r.deadline_valid = 1'b1;
				r.next_deadline = tbl_due[i];
			end
		return r;
	endfunction

	// Stimulus helpers; clock_now never decreases, but some commands carry other times.
	logic [TIME_W-1:0] clock_now = '0;

	task automatic push_cmd(kind_t k, int h, logic [ID_BITS-1:0] iv, logic os,
			logic [ID_BITS-1:0] sid, logic [TIME_W-1:0] t, logic hold = 1'b0);
		in_item_t c;
		c.kind = k;
		c.handler = HANDLER_BITS'(h);
		c.interval = iv;
		c.fire_once = os;
		c.stop_id = sid;
		c.now = t;
		pending_cmds.push_back(c);
		hold_until_drained.push_back(hold);
	endtask

	function automatic logic [ID_BITS-1:0] rand_interval();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return $urandom;
			2: return $urandom_range(1, 4);
			default: return $urandom_range(1, 300);
		endcase
	endfunction

	initial begin
		logic [ID_BITS-1:0] max_id;
		int h;
		max_id = 0;
		// Directed part: the table fills up, overflows, and is drained by stop
		// and tick; a handler is removed and later adds for it are refused.
		for (int i = 0; i < 16; i++)
			push_cmd(KIND_ADD, i % 4, (i == 0) ? '1 : i, i[0], '0,
				(i == 1) ? TIME_TOP : 48'd10);
		push_cmd(KIND_ADD, 5, 7, 1'b0, '1, 48'd10);     // table full
		push_cmd(KIND_STOP, 0, '1, 1'b1, 32'd0, '1);    // stop of id zero
		push_cmd(KIND_STOP, 0, 0, 1'b0, 32'd3, 48'd0);
		push_cmd(KIND_STOP, 0, 0, 1'b0, 32'hFFFF_FFFF, 48'd0);
		push_cmd(KIND_TICK, 15, 0, 1'b0, 0, 48'd12);
		push_cmd(KIND_TICK, 0, 0, 1'b0, 0, 48'd20);
		push_cmd(KIND_REMOVE, 3, 0, 1'b0, 0, 48'd0);
		push_cmd(KIND_ADD, 3, 5, 1'b0, 0, 48'd30);       // refused: removed
		push_cmd(KIND_TICK, 0, 0, 1'b0, 0, TIME_TOP, 1'b1);
		clock_now = 48'd100;
		// Random part, mostly plausible timer traffic; handler 3 stays removed.
		for (int n = 0; n < 950; n++) begin
			clock_now += TIME_W'($urandom_range(0, 40));
			h = $urandom_range(0, 15);
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6:
					push_cmd(KIND_ADD, h, rand_interval(), 1'($urandom_range(0, 1)),
						$urandom, clock_now);
				7, 8, 9:
					push_cmd(KIND_STOP, h, $urandom, 1'($urandom_range(0, 1)),
						($urandom_range(0, 7) == 0) ? $urandom :
						max_id - $urandom_range(0, 20), clock_now);
				10:
					if ($urandom_range(0, 9) == 0 || h == 3)
						push_cmd(KIND_REMOVE, h, $urandom, 1'b0, $urandom, clock_now);
					else
						push_cmd(KIND_TICK, h, $urandom, 1'b1, $urandom, clock_now);
				default:
					push_cmd(KIND_TICK, h, $urandom, 1'($urandom_range(0, 1)), $urandom,
						($urandom_range(0, 30) == 0) ? TIME_W'({$urandom, $urandom}) :
						clock_now, n % 300 == 150);
			endcase
			max_id += 1;
		end
		// Removing every handler clears the table; a last add is then refused.
		for (int i = 0; i < OWNERS; i++) push_cmd(KIND_REMOVE, i, 0, 1'b0, 0, '1);
		push_cmd(KIND_ADD, 9, '1, 1'b0, 0, '1);
	end

	// Reset and the end of the run.
	int idle_cycles = 0;
	initial begin
		id_counter = '0;
		for (int i = 0; i < SLOTS; i++) tbl_used[i] = 1'b0;
		for (int i = 0; i < OWNERS; i++) owner_gone[i] = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done && expected_results.size() == 0);
		repeat (80) @(posedge clk);
		if (failures == 0)
			$display("software_timer_table_top regression: pass");
		else
			$display("software_timer_table_top regression: fail");
		$finish;
	end

	// Driver: bursts of transactions with random gaps; at marked items it waits
	// for every outstanding result before offering the item.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(timer_table_apply(in_item));
				pending_cmds.delete(0);
				hold_until_drained.delete(0);
				if (pending_cmds.size() == 0) stim_done <= 1'b1;
			end
			if (!in_valid || !in_stall) begin
				if (pending_cmds.size() > 0 && !(in_valid && !in_stall &&
						pending_cmds.size() == 0)) begin
					if (hold_until_drained[0] && (expected_results.size() != 0 ||
							(in_valid && !in_stall))) begin
						in_valid <= 1'b0;
					end else if (gap_left > 0) begin
						gap_left <= gap_left - 1;
						in_valid <= 1'b0;
					end else begin
						in_valid <= 1'b1;
						in_item <= pending_cmds[0];
						if (burst_left == 0) begin
							burst_left <= $urandom_range(1, 12);
							gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
						end else begin
							burst_left <= burst_left - 1;
						end
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall pattern: alternating phases of free flow and heavy stall.
	int stall_phase = 0;
	always @(posedge clk) begin
		stall_phase <= (stall_phase + 1) % 512;
		if (stall_phase < 128)
			out_stall <= 1'b0;
		else if (stall_phase < 320)
			out_stall <= ($urandom_range(0, 3) != 0);
		else
			out_stall <= ($urandom_range(0, 1) == 0);
	end

	// Monitor and watchdog.
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("software_timer_table_top regression: fail");
				$finish;
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with nothing expected");
					failures <= failures + 1;
				end else begin
					exp_r = expected_results[0];
					expected_results.delete(0);
					if (out_item !== exp_r) begin
						failures <= failures + 1;
						if (out_item.status !== exp_r.status)
							$error("status exp %0d got %0d", exp_r.status, out_item.status);
						if (out_item.new_timer_id !== exp_r.new_timer_id)
							$error("new_timer_id exp %0d got %0d", exp_r.new_timer_id,
								out_item.new_timer_id);
						if (out_item.fired !== exp_r.fired)
							$error("fired exp %0d got %0d", exp_r.fired, out_item.fired);
						if (out_item.fired_timer_id !== exp_r.fired_timer_id)
							$error("fired_timer_id exp %0d got %0d", exp_r.fired_timer_id,
								out_item.fired_timer_id);
						if (out_item.fired_handler !== exp_r.fired_handler)
							$error("fired_handler exp %0d got %0d", exp_r.fired_handler,
								out_item.fired_handler);
						if (out_item.deadline_valid !== exp_r.deadline_valid)
							$error("deadline_valid exp %0d got %0d", exp_r.deadline_valid,
								out_item.deadline_valid);
						if (out_item.next_deadline !== exp_r.next_deadline)
							$error("next_deadline exp %0d got %0d", exp_r.next_deadline,
								out_item.next_deadline);
					end
				end
			end
		end
	end

endmodule

/* files.f */
hdl/stt_pkg.sv
hdl/stt_ctrl.sv
hdl/stt_datapath.sv
hdl/software_timer_table_top.sv
test/testbench.sv
